@@ rtl/core/pkrt_pkg.sv @@
// ----------------------------------------------------------------------------
// pkrt_pkg: shared definitions for the position keyed record table
// Sizes, operation codes, the record layout and the store request bundle.
// ----------------------------------------------------------------------------
package pkrt_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W       = 8;

	localparam logic [2:0] OP_SET_COUNT = 3'd0;
	localparam logic [2:0] OP_WRITE     = 3'd1;
	localparam logic [2:0] OP_READ      = 3'd2;
	localparam logic [2:0] OP_EXISTS    = 3'd3;
	localparam logic [2:0] OP_DELETE    = 3'd4;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] owner;
		logic [7:0] armour;
		logic [7:0] shells;
		logic [7:0] mines;
	} rec_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		rec_t              wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

@@ rtl/core/pkrt_store.sv @@
// ----------------------------------------------------------------------------
// pkrt_store: record storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pkrt_store (
	input  logic              clk,
	input  pkrt_pkg::mem_req_t req,
	output pkrt_pkg::rec_t     rd_data
);

	pkrt_pkg::rec_t mem [pkrt_pkg::MAX_ENTRIES];
	pkrt_pkg::rec_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[req.raddr];
	end

	assign rd_data = rd_q;

endmodule

@@ rtl/core/position_keyed_record_table_top.sv @@
// ----------------------------------------------------------------------------
// position_keyed_record_table_top: table of position keyed records
// Set count, write, read, exists-at-position and delete-at-position over a
// small record store, one operation per start, one result beat per operation.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its result beat
// appears on the result ports for exactly one cycle with done high, and the
// receiver cannot stall it. Set count, write, unused codes and a read of a
// slot outside the count return their beat in the next cycle without raising
// busy. A valid read moves to a read state for the registered store data and
// returns its beat from there. Exists walks the live records in order, a fetch
// state and a compare state per record, and ends at the first match or once
// past the last live record. Delete with no match runs as exists; a delete
// that finds a match then moves every later record down one slot, a read
// state and a write state per record, and lowers the live count. A new
// operation can be taken in the cycle its result beat is out. This sequence
// comes from the single read port of the record store and the one compare
// and increment unit that walks it.
// ----------------------------------------------------------------------------
module position_keyed_record_table_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] operation,
	input  logic [7:0] new_count,
	input  logic [4:0] slot_number,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] owner_in,
	input  logic [7:0] armour_in,
	input  logic [7:0] shells_in,
	input  logic [7:0] mines_in,
	output logic       done,
	output logic       hit,
	output logic [7:0] rec_x,
	output logic [7:0] rec_y,
	output logic [7:0] rec_owner,
	output logic [7:0] rec_armour,
	output logic [7:0] rec_shells,
	output logic [7:0] rec_mines,
	output logic [4:0] live_count
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_FETCH = 6'b000100,
		ST_CMP   = 6'b001000,
		ST_SH_RD = 6'b010000,
		ST_SH_WR = 6'b100000
	} state_t;

	state_t                      state_q, state_d;
	logic [pkrt_pkg::CNT_W-1:0]  idx_q, idx_d, idx_inc;
	logic [pkrt_pkg::CNT_W-1:0]  count_q, count_d;
	logic [2:0]                  op_q;
	logic [7:0]                  key_x_q, key_y_q;
	logic                        done_q, hit_q;
	pkrt_pkg::rec_t              rec_q;

	pkrt_pkg::mem_req_t          req;
	pkrt_pkg::rec_t              rd_data;

	logic                        accept, slot_ok, cnt_ok, match;
	logic [pkrt_pkg::ADDR_W-1:0] slot_addr;
	logic                        fin, fin_hit, fin_rd;

	pkrt_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	assign accept    = start && (state_q == ST_IDLE);
	assign slot_addr = pkrt_pkg::ADDR_W'(slot_number - 5'd1);
	assign slot_ok   = (slot_number != 5'd0)
		&& (pkrt_pkg::CMP_W'(slot_number) <= pkrt_pkg::CMP_W'(count_q))
		&& (pkrt_pkg::CMP_W'(slot_number) <= pkrt_pkg::CMP_W'(pkrt_pkg::MAX_ENTRIES));
	assign cnt_ok    = (new_count <= pkrt_pkg::CMP_W'(pkrt_pkg::MAX_ENTRIES));
	assign match     = (rd_data.x == key_x_q) && (rd_data.y == key_y_q);
	assign idx_inc   = idx_q + pkrt_pkg::CNT_W'(1);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		count_d     = count_q;
		fin         = 1'b0;
		fin_hit     = 1'b0;
		fin_rd      = 1'b0;
		req.we      = 1'b0;
		req.waddr   = idx_q[pkrt_pkg::ADDR_W-1:0];
		req.wdata   = rd_data;
		req.raddr   = idx_q[pkrt_pkg::ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				req.raddr = slot_addr;
				if (accept) begin
					unique case (operation) inside
						pkrt_pkg::OP_SET_COUNT: begin
							fin     = 1'b1;
							fin_hit = cnt_ok;
							if (cnt_ok) begin
								count_d = pkrt_pkg::CNT_W'(new_count);
							end
						end
						pkrt_pkg::OP_WRITE: begin
							fin       = 1'b1;
							fin_hit   = slot_ok;
							req.we    = slot_ok;
							req.waddr = slot_addr;
							req.wdata = '{x: pos_x, y: pos_y, owner: owner_in,
								armour: armour_in, shells: shells_in, mines: mines_in};
						end
						pkrt_pkg::OP_READ: begin
							if (slot_ok) begin
								state_d = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						pkrt_pkg::OP_EXISTS, pkrt_pkg::OP_DELETE: begin
							idx_d   = '0;
							state_d = ST_FETCH;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				fin     = 1'b1;
				fin_hit = 1'b1;
				fin_rd  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_FETCH: begin
				// past the last live record: no match
				if (idx_q >= count_q) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (match) begin
					if (op_q == pkrt_pkg::OP_DELETE) begin
						state_d = ST_SH_RD;
					end else begin
						fin     = 1'b1;
						fin_hit = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					idx_d   = idx_inc;
					state_d = ST_FETCH;
				end
			end
			ST_SH_RD: begin
				// fetch the next record to move down, or close out the delete
				req.raddr = idx_inc[pkrt_pkg::ADDR_W-1:0];
				if (idx_inc < count_q) begin
					state_d = ST_SH_WR;
				end else begin
					count_d = count_q - pkrt_pkg::CNT_W'(1);
					fin     = 1'b1;
					fin_hit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SH_WR: begin
				req.we    = 1'b1;
				req.waddr = idx_q[pkrt_pkg::ADDR_W-1:0];
				req.wdata = rd_data;
				idx_d     = idx_inc;
				state_d   = ST_SH_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			count_q <= '0;
			op_q    <= pkrt_pkg::OP_SET_COUNT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			done_q  <= fin;
			if (accept) begin
				op_q <= operation;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_x_q <= pos_x;
			key_y_q <= pos_y;
		end
		if (fin) begin
			hit_q <= fin_hit;
			rec_q <= fin_rd ? rd_data : '0;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign hit        = hit_q;
	assign rec_x      = rec_q.x;
	assign rec_y      = rec_q.y;
	assign rec_owner  = rec_q.owner;
	assign rec_armour = rec_q.armour;
	assign rec_shells = rec_q.shells;
	assign rec_mines  = rec_q.mines;
	assign live_count = 5'(count_q);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result beat while sequencer busy");

	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done_q || busy))
		else $error("accepted operation produced neither beat nor busy");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pkrt_pkg::CNT_W'(pkrt_pkg::MAX_ENTRIES))
		else $error("live count above capacity");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SH_RD) || (state_q == ST_SH_WR)) |-> (idx_q < count_q))
		else $error("compaction index outside live records");
`endif

endmodule
